// ===== sv/lrxc_pkg.sv =====
// Package for the LCG rotating XOR group cipher.
// Holds generator constants, config indexes, control structs and rotate helpers.
// No dependencies.
package lrxc_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = 3;
  localparam int AMT_W  = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [WORD_W-1:0] LCG_MUL   = 32'h0019_660d;
  localparam logic [WORD_W-1:0] LCG_ADD   = 32'h3c6e_f35f;
  localparam logic [WORD_W-1:0] KEY_RESET = 32'h0003_857a;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b1;

  // reciprocal of 3 for a 16-bit dividend: q = (y * RECIP3) >> RECIP3_SH
  localparam logic [15:0] RECIP3    = 16'haaab;
  localparam int          RECIP3_SH = 17;

  typedef struct packed {
    logic       load;      // take a new item, reseed if asked, first generator step
    logic       step;      // one generator step
    logic       cap_dir;
    logic       cap_amt;
    logic       cap_key;
    logic       load_out;
    logic [1:0] key_idx;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
  } status_t;

  function automatic logic [WORD_W-1:0] width_mask(input logic [CNT_W-1:0] cnt);
    logic [WORD_W-1:0] m;
    m = '0;
    case (cnt)
      3'd1: m = 32'h0000_00ff;
      3'd2: m = 32'h0000_ffff;
      3'd3: m = 32'h00ff_ffff;
      3'd4: m = 32'hffff_ffff;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] x,
                                                 input logic [AMT_W-1:0] a,
                                                 input logic [CNT_W-1:0] cnt);
    logic [15:0] d8;
    logic [31:0] d16;
    logic [47:0] d24;
    logic [63:0] d32;
    logic [WORD_W-1:0] r;
    d8  = '0;
    d16 = '0;
    d24 = '0;
    d32 = '0;
    r   = '0;
    case (cnt)
      3'd1: begin
        d8 = {x[7:0], x[7:0]} << a[2:0];
        r  = {24'd0, d8[15:8]};
      end
      3'd2: begin
        d16 = {x[15:0], x[15:0]} << a[3:0];
        r   = {16'd0, d16[31:16]};
      end
      3'd3: begin
        d24 = {x[23:0], x[23:0]} << a;
        r   = {8'd0, d24[47:24]};
      end
      3'd4: begin
        d32 = {x, x} << a;
        r   = d32[63:32];
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] rot_right(input logic [WORD_W-1:0] x,
                                                  input logic [AMT_W-1:0] a,
                                                  input logic [CNT_W-1:0] cnt);
    logic [15:0] d8;
    logic [31:0] d16;
    logic [47:0] d24;
    logic [63:0] d32;
    logic [WORD_W-1:0] r;
    d8  = '0;
    d16 = '0;
    d24 = '0;
    d32 = '0;
    r   = '0;
    case (cnt)
      3'd1: begin
        d8 = {x[7:0], x[7:0]} >> a[2:0];
        r  = {24'd0, d8[7:0]};
      end
      3'd2: begin
        d16 = {x[15:0], x[15:0]} >> a[3:0];
        r   = {16'd0, d16[15:0]};
      end
      3'd3: begin
        d24 = {x[23:0], x[23:0]} >> a;
        r   = {8'd0, d24[23:0]};
      end
      3'd4: begin
        d32 = {x, x} >> a;
        r   = d32[31:0];
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/lrxc_if.sv =====
// Valid/ready channel interfaces for the cipher's input and result items.
// Depends on lrxc_pkg for field widths.
interface lrxc_in_if;
  logic                        valid;
  logic                        ready;
  logic [lrxc_pkg::WORD_W-1:0] in_word;
  logic [lrxc_pkg::CNT_W-1:0]  byte_count;
  logic                        restart;

  modport source (output valid, output in_word, output byte_count, output restart,
                  input ready);
  modport sink   (input valid, input in_word, input byte_count, input restart,
                  output ready);
endinterface

interface lrxc_out_if;
  logic                        valid;
  logic                        ready;
  logic [lrxc_pkg::WORD_W-1:0] out_word;
  logic [lrxc_pkg::CNT_W-1:0]  out_count;

  modport source (output valid, output out_word, output out_count, input ready);
  modport sink   (input valid, input out_word, input out_count, output ready);
endinterface

// ===== sv/lrxc_ctrl.sv =====
// Controller FSM: sequences generator draws for one item and the result hand-off.
// Depends on lrxc_pkg (cmd_t, status_t).
module lrxc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lrxc_pkg::status_t st,
  output lrxc_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIR  = 3'd1;
  localparam logic [2:0] S_AMT  = 3'd2;
  localparam logic [2:0] S_KEY  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state, state_next;
  logic [1:0] key_idx, key_idx_next;
  logic [lrxc_pkg::CNT_W-1:0] cnt_m1;

  assign cnt_m1   = st.count - 3'd1;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    key_idx_next = key_idx;
    cmd          = '0;
    cmd.key_idx  = key_idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIR;
        end
      end
      S_DIR: begin
        cmd.cap_dir = 1'b1;
        if (st.count == 3'd0) begin
          state_next = S_FIN;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_AMT;
        end
      end
      S_AMT: begin
        cmd.cap_amt  = 1'b1;
        cmd.step     = 1'b1;
        key_idx_next = cnt_m1[1:0];
        state_next   = S_KEY;
      end
      S_KEY: begin
        cmd.cap_key = 1'b1;
        if (key_idx == 2'd0) begin
          state_next = S_FIN;
        end else begin
          cmd.step     = 1'b1;
          key_idx_next = key_idx - 2'd1;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_idx   <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      key_idx <= key_idx_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/lrxc_dp.sv =====
// Datapath: config registers, LCG seed with one multiply-add, draw capture,
// group transform and result register. Depends on lrxc_pkg.
module lrxc_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lrxc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lrxc_pkg::WORD_W-1:0]        cfg_data,
  input  logic [lrxc_pkg::WORD_W-1:0]        in_word,
  input  logic [lrxc_pkg::CNT_W-1:0]         byte_count,
  input  logic                               restart,
  input  lrxc_pkg::cmd_t                     cmd,
  output lrxc_pkg::status_t                  st,
  output logic [lrxc_pkg::WORD_W-1:0]        out_word,
  output logic [lrxc_pkg::CNT_W-1:0]         out_count
);

  logic [lrxc_pkg::WORD_W-1:0] cipher_key;
  logic                        encrypt_mode;
  logic [lrxc_pkg::WORD_W-1:0] seed;
  logic [lrxc_pkg::WORD_W-1:0] word;
  logic [lrxc_pkg::CNT_W-1:0]  count;
  logic                        dir;
  logic [lrxc_pkg::AMT_W-1:0]  amt;
  logic [lrxc_pkg::WORD_W-1:0] keyword;

  logic [lrxc_pkg::WORD_W-1:0] seed_src, seed_next;
  logic [lrxc_pkg::CNT_W-1:0]  count_clamp;
  logic [12:0]                 hi13;
  logic [28:0]                 q_prod;
  logic [12:0]                 q3;
  logic [14:0]                 r3_full;
  logic [lrxc_pkg::AMT_W-1:0]  amt_draw;
  logic [lrxc_pkg::WORD_W-1:0] data_m, pre, rotl_v, rotr_v, rot_v, result;
  logic                        go_left;

  assign st.count = count;

  assign seed_src  = (cmd.load && restart) ? cipher_key : seed;
  assign seed_next = seed_src * lrxc_pkg::LCG_MUL + lrxc_pkg::LCG_ADD;

  assign count_clamp = (byte_count > 3'd4) ? 3'd4 : byte_count;

  // (seed >> 16) mod 24 = ((seed >> 19) mod 3) * 8 + seed[18:16]
  assign hi13    = seed[31:19];
  assign q_prod  = {16'd0, hi13} * {13'd0, lrxc_pkg::RECIP3};
  assign q3      = q_prod[lrxc_pkg::RECIP3_SH +: 12] == 12'd0 ? 13'd0
                   : {1'b0, q_prod[lrxc_pkg::RECIP3_SH +: 12]};
  assign r3_full = {2'd0, hi13} - ({2'd0, q3} + {1'b0, q3, 1'b0});

  always_comb begin
    amt_draw = '0;
    case (count)
      3'd1: amt_draw = {2'd0, seed[18:16]};
      3'd2: amt_draw = {1'b0, seed[19:16]};
      3'd3: amt_draw = {r3_full[1:0], seed[18:16]};
      3'd4: amt_draw = seed[20:16];
      default: amt_draw = '0;
    endcase
  end

  // encrypt: xor then rotate (left on dir); decrypt: rotate the other way then xor
  assign data_m  = word & lrxc_pkg::width_mask(count);
  assign pre     = encrypt_mode ? (data_m ^ keyword) : data_m;
  assign go_left = encrypt_mode ? dir : !dir;
  assign rotl_v  = lrxc_pkg::rot_left(pre, amt, count);
  assign rotr_v  = lrxc_pkg::rot_right(pre, amt, count);
  assign rot_v   = go_left ? rotl_v : rotr_v;
  assign result  = (encrypt_mode ? rot_v : (rot_v ^ keyword))
                   & lrxc_pkg::width_mask(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key   <= lrxc_pkg::KEY_RESET;
      encrypt_mode <= 1'b0;
      seed         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lrxc_pkg::CFG_KEY:  cipher_key   <= cfg_data;
          lrxc_pkg::CFG_MODE: encrypt_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load || cmd.step) begin
        seed <= seed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word    <= in_word;
      count   <= count_clamp;
      keyword <= '0;
    end
    if (cmd.cap_dir) begin
      dir <= seed[16];
    end
    if (cmd.cap_amt) begin
      amt <= amt_draw;
    end
    if (cmd.cap_key) begin
      case (cmd.key_idx)
        2'd0: keyword[7:0]   <= seed[23:16];
        2'd1: keyword[15:8]  <= seed[23:16];
        2'd2: keyword[23:16] <= seed[23:16];
        2'd3: keyword[31:24] <= seed[23:16];
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      out_word  <= result;
      out_count <= count;
    end
  end

endmodule

// ===== sv/lcg_rotating_xor_cipher.sv =====
// Top level: LCG-keyed rotating XOR group cipher, controller plus datapath.
// Per item: accept in idle, direction draw, amount draw, one key-byte capture per byte, then result
// load (an empty group goes from direction draw to result load), byte_count above 4 counting as 4;
// a result still waiting in the output register stalls the result load. One draw per cycle on the
// single LCG multiply-add, then key capture and result load. One in flight: no accept until idle.
// Reset (rst, synchronous): FSM idle, no result valid, seed 0, key 0x3857A, decrypt mode.
module lcg_rotating_xor_cipher (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lrxc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrxc_pkg::WORD_W-1:0]    cfg_data,
  lrxc_in_if.sink                        in_ch,
  lrxc_out_if.source                     out_ch
);

  lrxc_pkg::cmd_t    cmd;
  lrxc_pkg::status_t st;
  logic              in_ready;
  logic              out_valid;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  lrxc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  lrxc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_word    (in_ch.in_word),
    .byte_count (in_ch.byte_count),
    .restart    (in_ch.restart),
    .cmd        (cmd),
    .st         (st),
    .out_word   (out_ch.out_word),
    .out_count  (out_ch.out_count)
  );

endmodule

// ===== sv/lrxc_checker.sv =====
// Port-level checker for lcg_rotating_xor_cipher, attached by bind.
// Depends on lrxc_pkg for widths.
module lrxc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lrxc_pkg::WORD_W-1:0] out_word,
  input logic [lrxc_pkg::CNT_W-1:0]  out_count
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_count))
    else $error("result dropped or changed while stalled");

  // one item at a time: no new accept right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // no result appears the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared without processing");

  // bytes above the count are zero
  a_upper_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_count <= 3'd4) &&
                  ((out_count != 3'd1) || (out_word[31:8] == 24'd0)) &&
                  ((out_count != 3'd2) || (out_word[31:16] == 16'd0)) &&
                  ((out_count != 3'd3) || (out_word[31:24] == 8'd0)) &&
                  ((out_count != 3'd0) || (out_word == 32'd0)))
    else $error("unused result bytes not zero");

endmodule

bind lcg_rotating_xor_cipher lrxc_checker u_lrxc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.out_word),
  .out_count (out_ch.out_count)
);
